// ===== hdl/encoder_speed_averager_assert.svh =====
// ----------------------------------------------------------------------------
// Encoder speed averager assertion macros
// Concurrent assertion wrappers clocked on clk_i, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_AVERAGER_ASSERT_SVH
`define ENCODER_SPEED_AVERAGER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ESA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("encoder_speed_averager: assertion failed");
`define ESA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("encoder_speed_averager: assertion failed");
`else
`define ESA_ASSERT(lbl, prop)
`define ESA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hdl/esa_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder speed averager package
// Shared widths, reset values, request and register codes, unit status type.
// ----------------------------------------------------------------------------
package esa_pkg;

  localparam int DATA_W       = 16;
  localparam int IN_TDATA_W   = 24;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 32;
  localparam int CFG_IDX_W    = 1;
  localparam int MUL_A_W      = 22;
  localparam int MUL_B_W      = 16;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;

  localparam int RING_DEPTH_DEF = 8;

  localparam logic [DATA_W-1:0] CPR_RESET  = 16'd4096;
  localparam logic [DATA_W-1:0] RATE_RESET = 16'd100;

  typedef enum logic [IN_TUSER_W-1:0] {
    REQ_OVERFLOW = 2'd0,
    REQ_SAMPLE   = 2'd1,
    REQ_CLEAR    = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPR  = 1'b0,
    CFG_RATE = 1'b1
  } cfg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== hdl/esa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module esa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/esa_mul.sv =====
// ----------------------------------------------------------------------------
// Encoder speed averager serial multiplier
// Shift-add multiplier taking one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module esa_mul #(
  parameter int AW = esa_pkg::MUL_A_W,
  parameter int BW = esa_pkg::MUL_B_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [AW-1:0]       a_i,
  input  logic [BW-1:0]       b_i,
  output logic [AW+BW-1:0]    prod_o,
  output esa_pkg::unit_stat_t stat_o
);

  import esa_pkg::*;

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_q;
  logic [BW-1:0] b_q;
  logic [PW-1:0] acc_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[PW-2:0], 1'b0} + (b_q[BW-1] ? PW'(a_q) : '0);
      b_q   <= {b_q[BW-2:0], 1'b0};
    end
  end

  assign prod_o      = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== hdl/esa_div.sv =====
// ----------------------------------------------------------------------------
// Encoder speed averager serial divider
// Restoring unsigned divider retiring one quotient bit per cycle.
// ----------------------------------------------------------------------------
module esa_div #(
  parameter int NW = esa_pkg::PROD_W,
  parameter int DW = esa_pkg::DATA_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NW-1:0]       num_i,
  input  logic [DW-1:0]       den_i,
  output logic [NW-1:0]       quot_o,
  output esa_pkg::unit_stat_t stat_o
);

  import esa_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_q <= {num_q[NW-2:0], ge};
    end
  end

  assign quot_o      = num_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== hdl/encoder_speed_averager.sv =====
// ----------------------------------------------------------------------------
// Encoder speed averager
// Per-sample encoder delta and ring-averaged rpm for one encoder channel.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tuser: req_type; tdata: counter_value, count_down
// m_axis    out        tdata: delta_counts, avg_rpm
// cfg       in         index 0 counts_per_rev, index 1 sample_rate_hz
//
// Overflow and clear transactions complete in the idle state. A speed sample
// takes two passes through the 38-step serial divider and two through the
// 16-step serial multiplier (one multiplier pass for the first after a clear).
// Reset clears history and loads default configuration at once; no sweep.
// A finished result waits in the output register while the next item is taken;
// the following sample stalls at its end until that register is free.
// ----------------------------------------------------------------------------
`include "encoder_speed_averager_assert.svh"

module encoder_speed_averager #(
  parameter int RING_DEPTH = esa_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] counter_value, [16] count_down, [23:17] zero
  input  logic [esa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] req_type
  input  logic [esa_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] delta_counts, [31:16] avg_rpm
  output logic [esa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [esa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [esa_pkg::DATA_W-1:0]        cfg_data_i
);

  import esa_pkg::*;

  localparam int PW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W = DATA_W + $clog2(RING_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_RING,
    ST_AVG,
    ST_SCALE,
    ST_RPM,
    ST_DONE
  } state_e;

  state_e                   state_q;
  logic [DATA_W-1:0]        cpr_q;
  logic [DATA_W-1:0]        rate_q;
  logic [DATA_W-1:0]        ovf_q;
  logic [DATA_W-1:0]        prev_q;
  logic                     first_q;
  logic [PW-1:0]            pos_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [RING_DEPTH-1:0]    valid_q;
  logic                     m_tvalid_q;
  logic [OUT_TDATA_W-1:0]   m_tdata_q;

  logic [DATA_W-1:0]        cnt_q;
  logic                     down_q;
  logic [DATA_W-1:0]        delta_q;
  logic                     neg_q;
  logic [DATA_W-1:0]        rpm_q;

  req_e                     req;
  logic                     in_acc;
  logic                     sample_acc;

  logic                     mul_start;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [PROD_W-1:0]        mul_p;
  unit_stat_t               mul_stat;

  logic                     div_start;
  logic [PROD_W-1:0]        div_n;
  logic [DATA_W-1:0]        div_d;
  logic [PROD_W-1:0]        div_q;
  unit_stat_t               div_stat;

  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] old_s;
  logic signed [DATA_W-1:0] delta_s;
  logic signed [SUM_W-1:0]  sum_new;
  logic [SUM_W-1:0]         sum_mag;
  logic [MUL_A_W-1:0]       rate60;
  logic [DATA_W-1:0]        cpr_div;
  logic [DATA_W-1:0]        moved;
  logic [DATA_W-1:0]        wraps;
  logic [DATA_W-1:0]        delta_new;
  logic [DATA_W-1:0]        quot16;

  assign req           = req_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign sample_acc    = in_acc && (req == REQ_SAMPLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  assign rate60  = MUL_A_W'({rate_q, 6'b0}) - MUL_A_W'({rate_q, 2'b0});
  assign cpr_div = (cpr_q == '0) ? DATA_W'(1) : cpr_q;

  assign mul_start = (sample_acc && !first_q) || (state_q == ST_AVG && div_stat.done);
  assign mul_a     = (state_q == ST_IDLE) ? MUL_A_W'(cpr_q) : rate60;
  assign mul_b     = (state_q == ST_IDLE) ? ovf_q : div_q[MUL_B_W-1:0];

  assign old_s   = valid_q[pos_q] ? signed'(ram_rdata) : '0;
  assign delta_s = signed'(delta_q);
  assign sum_new = sum_q - SUM_W'(old_s) + SUM_W'(delta_s);
  assign sum_mag = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

  assign div_start = (state_q == ST_RING) || (state_q == ST_SCALE && mul_stat.done);
  assign div_n     = (state_q == ST_RING) ? PROD_W'(sum_mag) : mul_p;
  assign div_d     = (state_q == ST_RING) ? DATA_W'(RING_DEPTH) : cpr_div;

  assign moved     = cnt_q - prev_q;
  assign wraps     = mul_p[DATA_W-1:0];
  assign delta_new = down_q ? (wraps - moved) : (moved + wraps);
  assign quot16    = div_q[DATA_W-1:0];

  esa_mul #(
    .AW(MUL_A_W),
    .BW(MUL_B_W)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p),
    .stat_o (mul_stat)
  );

  esa_div #(
    .NW(PROD_W),
    .DW(DATA_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_n),
    .den_i  (div_d),
    .quot_o (div_q),
    .stat_o (div_stat)
  );

  esa_ram #(
    .WIDTH(DATA_W),
    .DEPTH(RING_DEPTH),
    .AW   (PW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_RING),
    .waddr_i(pos_q),
    .wdata_i(delta_q),
    .raddr_i(pos_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cpr_q      <= CPR_RESET;
      rate_q     <= RATE_RESET;
      ovf_q      <= '0;
      prev_q     <= '0;
      first_q    <= 1'b1;
      pos_q      <= '0;
      sum_q      <= '0;
      valid_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_CPR:  cpr_q  <= cfg_data_i;
          CFG_RATE: rate_q <= cfg_data_i;
          default:  cpr_q  <= cpr_q;
        endcase
      end
      if (m_tvalid_q && m_axis_tready && state_q != ST_DONE) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (req)
              REQ_OVERFLOW: begin
                if (ovf_q != '1) begin
                  ovf_q <= ovf_q + DATA_W'(1);
                end
              end
              REQ_CLEAR: begin
                valid_q <= '0;
                pos_q   <= '0;
                sum_q   <= '0;
                first_q <= 1'b1;
              end
              REQ_SAMPLE: begin
                state_q <= first_q ? ST_RING : ST_WRAP;
                first_q <= 1'b0;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_WRAP: begin
          if (mul_stat.done) begin
            state_q <= ST_RING;
          end
        end
        ST_RING: begin
          ovf_q          <= '0;
          prev_q         <= cnt_q;
          sum_q          <= sum_new;
          valid_q[pos_q] <= 1'b1;
          pos_q          <= (pos_q == PW'(RING_DEPTH - 1)) ? '0 : pos_q + PW'(1);
          state_q        <= ST_AVG;
        end
        ST_AVG: begin
          if (div_stat.done) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (mul_stat.done) begin
            state_q <= ST_RPM;
          end
        end
        ST_RPM: begin
          if (div_stat.done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid_q || m_axis_tready) begin
            m_tvalid_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      cnt_q   <= s_axis_tdata[DATA_W-1:0];
      down_q  <= s_axis_tdata[DATA_W];
      delta_q <= '0;
    end
    if (state_q == ST_WRAP && mul_stat.done) begin
      delta_q <= delta_new;
    end
    if (state_q == ST_RING) begin
      neg_q <= sum_new[SUM_W-1];
    end
    if (state_q == ST_RPM && div_stat.done) begin
      rpm_q <= neg_q ? (DATA_W'(0) - quot16) : quot16;
    end
    if (state_q == ST_DONE && (!m_tvalid_q || m_axis_tready)) begin
      m_tdata_q <= {rpm_q, delta_q};
    end
  end

  `ESA_ASSERT(a_out_from_done, $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
  `ESA_ASSERT_ALWAYS(a_units_exclusive, !rst_ni || !(mul_stat.busy && div_stat.busy))
  `ESA_ASSERT(a_sample_blocks, (s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_SAMPLE) |=> !s_axis_tready)
  `ESA_ASSERT(a_pos_range, pos_q <= PW'(RING_DEPTH - 1))

endmodule
